>>> rtl/core/oale_pkg.sv
// Package with the command, status, state and beat types of the ordered array list engine.
`default_nettype none

package oale_pkg;

   // Fixed field widths of the request and response beats.
   localparam int unsigned POS_W  = 6;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned CNT_W  = 7;

   typedef enum logic [2:0] {
      CMD_APPEND    = 3'd0,
      CMD_INSERT    = 3'd1,
      CMD_DELETE    = 3'd2,
      CMD_READ_LAST = 3'd3,
      CMD_READ_AT   = 3'd4,
      CMD_REPLACE   = 3'd5,
      CMD_CLEAR     = 3'd6,
      CMD_DUMP      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INS_FIN,
      S_RD_WAIT,
      S_DUMP_RD,
      S_DUMP_WAIT,
      S_EMIT
   } state_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic [POS_W-1:0]           position;
      logic signed [DATA_W-1:0]   value;
   } req_beat_type;

   typedef struct packed {
      status_type                 status;
      logic signed [DATA_W-1:0]   data;
      logic [CNT_W-1:0]           count;
      logic                       last;
   } rsp_beat_type;

endpackage

`default_nettype wire

>>> rtl/core/ordered_array_list_engine.sv
// Ordered list of signed words in a one-read, one-write memory, run by a small sequencer.
// Insert and delete shift the words one slot at a time, with a memory read and then a write per slot.
// A dump reads, waits for and emits each entry in list order; every beat waits for a free output register.
// A new request is taken once the previous command's last beat sits in the output register.
// Synchronous reset empties the list; stored words are left as they are.
`default_nettype none

module ordered_array_list_engine #(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire oale_pkg::req_beat_type req_payload,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      oale_pkg::rsp_beat_type rsp_payload
);
   import oale_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // Storage for the list words.
   logic [DATA_W-1:0] mem [DEPTH];

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   cmd_type           cmd_ff, cmd_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_beat_type      rsp_payload_ff, rsp_payload_in;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata;

   logic              accept, out_free;
   logic              is_full, is_empty;
   logic [CNT_W-1:0]  pos7, cnt7, idx7;
   logic [CW-1:0]     idx_m1;
   logic [CW-1:0]     cnt_m1;
   status_type        chk_status;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign pos7     = CNT_W'(pos_ff);
   assign cnt7     = CNT_W'(count_ff);
   assign idx7     = CNT_W'(idx_ff);
   assign idx_m1   = idx_ff - CW'(1);
   assign cnt_m1   = count_ff - CW'(1);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Status check of the latched command against the current count.
   always_comb begin
      chk_status = ST_OK;
      case (cmd_ff)
         CMD_APPEND: begin
            if (is_full) chk_status = ST_FULL;
         end
         CMD_INSERT: begin
            if (is_full) chk_status = ST_FULL;
            else if (pos7 > cnt7) chk_status = ST_RANGE;
         end
         CMD_DELETE, CMD_READ_AT, CMD_REPLACE: begin
            if (is_empty) chk_status = ST_EMPTY;
            else if (pos7 >= cnt7) chk_status = ST_RANGE;
         end
         CMD_READ_LAST, CMD_CLEAR, CMD_DUMP: begin
            if (is_empty) chk_status = ST_EMPTY;
         end
         default: chk_status = ST_OK;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (chk_status != ST_OK) begin
               state_in = S_EMIT;
            end else begin
               case (cmd_ff)
                  CMD_INSERT: state_in = (pos7 == cnt7) ? S_INS_FIN : S_SHIFT_RD;
                  CMD_DELETE: state_in = (pos7 + CNT_W'(1) == cnt7) ? S_EMIT : S_SHIFT_RD;
                  CMD_READ_LAST, CMD_READ_AT: state_in = S_RD_WAIT;
                  CMD_DUMP: state_in = S_DUMP_RD;
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (cmd_ff == CMD_INSERT) begin
               state_in = (CNT_W'(idx_m1) == pos7) ? S_INS_FIN : S_SHIFT_RD;
            end else begin
               state_in = (idx7 + CNT_W'(2) == cnt7) ? S_EMIT : S_SHIFT_RD;
            end
         end
         S_INS_FIN:   state_in = S_EMIT;
         S_RD_WAIT:   state_in = S_EMIT;
         S_DUMP_RD:   state_in = S_DUMP_WAIT;
         S_DUMP_WAIT: state_in = S_EMIT;
         S_EMIT: begin
            if (out_free) state_in = last_ff ? S_IDLE : S_DUMP_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath controls and register next values for each state.
   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      cmd_in         = cmd_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      status_in      = status_ff;
      data_in        = data_ff;
      last_in        = last_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff[AW-1:0];
      mem_wdata      = rd_data_ff;
      mem_re         = 1'b0;
      mem_raddr      = idx_ff[AW-1:0];
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_payload.cmd;
               pos_in = req_payload.position;
               val_in = req_payload.value;
            end
         end
         S_DECODE: begin
            status_in = chk_status;
            data_in   = '0;
            last_in   = 1'b1;
            if (chk_status == ST_OK) begin
               case (cmd_ff)
                  CMD_APPEND: begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[AW-1:0];
                     mem_wdata = val_ff;
                     count_in  = count_ff + CW'(1);
                  end
                  CMD_INSERT: idx_in = count_ff;
                  CMD_DELETE: begin
                     idx_in = CW'(pos_ff);
                     if (pos7 + CNT_W'(1) == cnt7) count_in = count_ff - CW'(1);
                  end
                  CMD_READ_LAST: begin
                     mem_re    = 1'b1;
                     mem_raddr = cnt_m1[AW-1:0];
                  end
                  CMD_READ_AT: begin
                     mem_re    = 1'b1;
                     mem_raddr = pos_ff[AW-1:0];
                  end
                  CMD_REPLACE: begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_ff[AW-1:0];
                     mem_wdata = val_ff;
                  end
                  CMD_CLEAR: count_in = '0;
                  CMD_DUMP:  idx_in   = '0;
                  default: count_in = count_ff;
               endcase
            end
         end
         // Fetch the neighbor that moves into the current slot.
         S_SHIFT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = (cmd_ff == CMD_INSERT) ? idx_m1[AW-1:0]
                                               : idx_ff[AW-1:0] + AW'(1);
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = rd_data_ff;
            if (cmd_ff == CMD_INSERT) begin
               idx_in = idx_m1;
            end else begin
               idx_in = idx_ff + CW'(1);
               if (idx7 + CNT_W'(2) == cnt7) count_in = count_ff - CW'(1);
            end
         end
         S_INS_FIN: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[AW-1:0];
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
         end
         S_RD_WAIT: data_in = rd_data_ff;
         S_DUMP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = idx_ff[AW-1:0];
         end
         S_DUMP_WAIT: begin
            data_in   = rd_data_ff;
            status_in = ST_OK;
            last_in   = (idx7 + CNT_W'(1) == cnt7);
         end
         // Hand the beat to the output register once it is free.
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_payload_in.status = status_ff;
               rsp_payload_in.data   = data_ff;
               rsp_payload_in.count  = cnt7;
               rsp_payload_in.last   = last_ff;
               if (!last_ff) idx_in = idx_ff + CW'(1);
            end
         end
         default: rsp_valid_in = rsp_valid_ff && rsp_stall;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      cmd_ff         <= cmd_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      status_ff      <= status_in;
      data_ff        <= data_in;
      last_ff        <= last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // List memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

endmodule

`default_nettype wire

>>> tb/sv/oale_list_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the response beats of the ordered array list engine.
`timescale 1ns / 1ps

package oale_list_scoreboard_pkg;

   import oale_pkg::*;

   parameter int unsigned LIST_DEPTH = 64;

   class list_scoreboard;

      logic signed [DATA_W-1:0] shadow_words [LIST_DEPTH];
      logic [CNT_W-1:0]         shadow_count;
      rsp_beat_type             expected_beats [$];
      int unsigned              failures;

      function new();
         shadow_count = '0;
         failures     = 0;
         foreach (shadow_words[i]) shadow_words[i] = '0;
      endfunction

      // Expected beats carry the entry count as it stands after the command.
      function void queue_beat(status_type st, logic signed [DATA_W-1:0] word, logic last_flag);
         rsp_beat_type beat;
         beat.status = st;
         beat.data   = word;
         beat.count  = shadow_count;
         beat.last   = last_flag;
         expected_beats.push_back(beat);
      endfunction

      function int unsigned pending();
         return expected_beats.size();
      endfunction

      // Apply one accepted request beat to the shadow list and queue what it should produce.
      function void note_request(req_beat_type req);
         status_type               st;
         logic signed [DATA_W-1:0] word;
         int unsigned              p;
         int unsigned              i;
         st   = ST_OK;
         word = '0;
         p    = req.position;
         case (req.cmd)
            CMD_APPEND: begin
               if (shadow_count >= LIST_DEPTH) begin
                  st = ST_FULL;
               end else begin
                  shadow_words[shadow_count] = req.value;
                  shadow_count++;
               end
            end
            CMD_INSERT: begin
               // A full list is reported before a bad position.
               if (shadow_count >= LIST_DEPTH) begin
                  st = ST_FULL;
               end else if (p > shadow_count) begin
                  st = ST_RANGE;
               end else begin
                  for (i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
                  shadow_words[p] = req.value;
                  shadow_count++;
               end
            end
            CMD_DELETE: begin
               if (shadow_count == 0) begin
                  st = ST_EMPTY;
               end else if (p >= shadow_count) begin
                  st = ST_RANGE;
               end else begin
                  for (i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
                  shadow_count--;
               end
            end
            CMD_READ_LAST: begin
               if (shadow_count == 0) st = ST_EMPTY;
               else word = shadow_words[shadow_count-1];
            end
            CMD_READ_AT: begin
               if (shadow_count == 0) st = ST_EMPTY;
               else if (p >= shadow_count) st = ST_RANGE;
               else word = shadow_words[p];
            end
            CMD_REPLACE: begin
               if (shadow_count == 0) st = ST_EMPTY;
               else if (p >= shadow_count) st = ST_RANGE;
               else shadow_words[p] = req.value;
            end
            CMD_CLEAR: begin
               if (shadow_count == 0) begin
                  st = ST_EMPTY;
               end else begin
                  foreach (shadow_words[k]) shadow_words[k] = '0;
                  shadow_count = '0;
               end
            end
            default: begin
               // A dump of a non-empty list gives one beat per entry in list order.
               if (shadow_count == 0) begin
                  st = ST_EMPTY;
               end else begin
                  for (i = 0; i < shadow_count; i++) begin
                     queue_beat(ST_OK, shadow_words[i], (i + 1 == shadow_count));
                  end
                  return;
               end
            end
         endcase
         queue_beat(st, word, 1'b1);
      endfunction

      // Compare one accepted response beat with the oldest expected beat.
      function void check_response(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("response beat with nothing expected: status %0d data %0d count %0d last %0d",
                   got.status, got.data, got.count, got.last);
            failures++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.data !== want.data) begin
            $error("data: expected %0d, actual %0d", want.data, got.data);
            failures++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            failures++;
         end
      endfunction

   endclass

endpackage

>>> tb/sv/tb_ordered_array_list_engine.sv
// Top-level testbench of the ordered array list engine: clock, reset, drivers and watchdog.
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;

   import oale_pkg::*;
   import oale_list_scoreboard_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 185;
   localparam int unsigned IDLE_PCT     = 17;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned STUCK_LIMIT  = 2000;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_beat_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_beat_type rsp_payload;

   list_scoreboard sb = new();

   // Shared between the sender and the receiver.
   bit steady       = 1'b0;
   bit hold_request = 1'b0;

   ordered_array_list_engine #(
      .DEPTH (LIST_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Offer one request beat, with an optional random gap first, and hold it until taken.
   task automatic send_request(input cmd_type cmd, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] word);
      req_beat_type beat;
      beat.cmd      = cmd;
      beat.position = pos;
      beat.value    = word;
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (!steady && $urandom_range(99) < IDLE_PCT) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(beat);
   endtask

   // Receiver: check accepted beats and choose the stall for the next cycle.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Watchdog: give up after too many cycles without any accepted beat.
   initial begin
      int unsigned stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
      end
      $display("[ordered_array_list_engine] ERROR");
      $finish;
   end

   // Stimulus: directed corner cases, then grow and shrink sweeps with noise.
   initial begin
      cmd_type          cmd;
      logic [POS_W-1:0] pos;
      int unsigned      fill;
      int unsigned      r;
      int unsigned      full_hits;
      bit               growing;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every command but append on an empty list, then build a short list with the value extremes.
      send_request(CMD_READ_LAST, 6'd0, 32'd0);
      send_request(CMD_DUMP, 6'd0, 32'd0);
      send_request(CMD_CLEAR, 6'd0, 32'd0);
      send_request(CMD_DELETE, 6'd0, 32'd0);
      send_request(CMD_READ_AT, 6'd63, 32'd0);
      send_request(CMD_REPLACE, 6'd0, 32'd7);
      send_request(CMD_INSERT, 6'd1, 32'd11);
      send_request(CMD_INSERT, 6'd0, 32'h8000_0000);
      send_request(CMD_APPEND, 6'd63, 32'h7FFF_FFFF);
      send_request(CMD_APPEND, 6'd0, 32'hFFFF_FFFF);
      // Insert at a position equal to the count behaves like an append.
      send_request(CMD_INSERT, 6'd3, 32'd0);
      send_request(CMD_INSERT, 6'd1, 32'h5A5A_5A5A);
      send_request(CMD_READ_AT, 6'd63, 32'd0);
      send_request(CMD_READ_AT, 6'd5, 32'd0);
      send_request(CMD_READ_AT, 6'd0, 32'd0);
      send_request(CMD_REPLACE, 6'd2, 32'h1234_5678);
      send_request(CMD_REPLACE, 6'd5, 32'd1);
      send_request(CMD_DELETE, 6'd5, 32'd0);
      send_request(CMD_DELETE, 6'd0, 32'd0);
      send_request(CMD_DELETE, 6'd3, 32'd0);
      send_request(CMD_READ_LAST, 6'd0, 32'd0);
      send_request(CMD_INSERT, 6'd63, 32'd3);
      send_request(CMD_DUMP, 6'd0, 32'd0);
      send_request(CMD_CLEAR, 6'd0, 32'd0);
      send_request(CMD_READ_LAST, 6'd0, 32'd0);

      growing   = 1'b1;
      full_hits = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 60 && n < 120);
         // Long receiver hold-off while the sender keeps offering.
         if (n == 100) hold_request = 1'b1;
         fill = 32'(sb.shadow_count);
         r    = $urandom_range(99);
         if (growing) begin
            if (r < 50) cmd = CMD_APPEND;
            else if (r < 78) cmd = CMD_INSERT;
            else if (r < 83) cmd = CMD_DELETE;
            else if (r < 88) cmd = CMD_READ_AT;
            else if (r < 92) cmd = CMD_REPLACE;
            else if (r < 95) cmd = CMD_READ_LAST;
            else if (r < 98) cmd = CMD_DUMP;
            else cmd = CMD_READ_AT;
         end else begin
            if (r < 70) cmd = CMD_DELETE;
            else if (r < 78) cmd = CMD_READ_AT;
            else if (r < 84) cmd = CMD_REPLACE;
            else if (r < 88) cmd = CMD_READ_LAST;
            else if (r < 92) cmd = CMD_DUMP;
            else if (r < 96) cmd = CMD_APPEND;
            else if (r < 98) cmd = CMD_INSERT;
            else cmd = CMD_CLEAR;
         end
         // Noise: any command, but no clear while the list is being filled.
         if ($urandom_range(99) < 10) begin
            cmd = cmd_type'($urandom_range(7));
            if (growing && cmd == CMD_CLEAR) cmd = CMD_APPEND;
         end
         if (cmd == CMD_INSERT) begin
            pos = POS_W'($urandom_range(fill));
         end else if (fill != 0 && (cmd == CMD_DELETE || cmd == CMD_READ_AT ||
                                    cmd == CMD_REPLACE)) begin
            pos = POS_W'($urandom_range(fill - 1));
         end else begin
            pos = POS_W'($urandom_range(63));
         end
         if ($urandom_range(99) < 10) pos = POS_W'($urandom_range(63));
         send_request(cmd, pos, $urandom());
         // Stay at full for a few beats, then drain back to empty.
         if (growing && sb.shadow_count == LIST_DEPTH) begin
            full_hits++;
            if (full_hits >= 4) growing = 1'b0;
         end else if (!growing && sb.shadow_count == 0) begin
            growing   = 1'b1;
            full_hits = 0;
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("[ordered_array_list_engine] OK");
      end else begin
         $display("[ordered_array_list_engine] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/oale_pkg.sv
rtl/core/ordered_array_list_engine.sv
tb/sv/oale_list_scoreboard_pkg.sv
tb/sv/tb_ordered_array_list_engine.sv
